// ----- rtl/fpio_pkg.sv -----
// Shared types, constants and codes for the file I/O enter/exit pairing block.
`default_nettype none

package fpio_pkg;

  // Pending table geometry
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Input mode codes
  localparam logic [1:0] MODE_ENTER = 2'd0;
  localparam logic [1:0] MODE_EXIT  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Result kind codes
  localparam logic [2:0] KIND_STORED    = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_MATCHED   = 3'd2;
  localparam logic [2:0] KIND_UNMATCHED = 3'd3;
  localparam logic [2:0] KIND_CLEARED   = 3'd4;

  localparam logic [63:0] TS_INVALID = {64{1'b1}};

  // One pending enter item as held in the table memory
  typedef struct packed {
    logic [31:0] order;
    logic [63:0] ts;
    logic [31:0] thread_id;
    logic        is_write;
    logic [31:0] main_device;
    logic [31:0] sub_device;
    logic [63:0] inode;
    logic [63:0] file_offset;
    logic [63:0] request_bytes;
    logic [63:0] enter_size;
    logic [63:0] file_id;
  } slot_t;

  // Fields of an exit item that the compare unit checks against
  typedef struct packed {
    logic [63:0] ts;
    logic [31:0] thread_id;
    logic        is_write;
    logic [31:0] main_device;
    logic [31:0] sub_device;
    logic [63:0] inode;
    logic [63:0] file_offset;
    logic [63:0] request_bytes;
    logic [63:0] actual_bytes;
  } exit_key_t;

  // Best candidate found so far during a scan
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [63:0]      ts;
    logic [63:0]      file_offset;
    logic [63:0]      enter_size;
    logic [63:0]      file_id;
  } best_t;

  // Compare-stage control from the sequencer
  typedef struct packed {
    logic             init;
    logic             cmp_en;
    logic             slot_valid;
    logic [IDX_W-1:0] idx;
  } cmp_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/file_io_enter_exit_pairing_top.sv -----
// Top level: pending table, valid bits, insert counter and scan sequencer.
//
//  Channel   Handshake                  Payload
//  input     start, busy                mode_i .. file_id_i
//  result    done_o (one-cycle strobe)  result_kind_o .. entry_file_id_o
//
// Enter, clear and unused-mode items are accepted at once; busy stays low and the
// result, if any, strobes on the next cycle. An exit item holds busy through the
// scan, tail and finish states: one table read per cycle through the single memory
// read port into the shared compare unit, the last compare in the tail state and
// the result formed in the finish state, which strobes as busy falls. Reset clears
// the valid bits and the insert counter at once; no clearing pass is needed.
// Results cannot be stalled.
`default_nettype none

module file_io_enter_exit_pairing_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode_i,
  input  wire logic        is_write_i,
  input  wire logic [63:0] timestamp_i,
  input  wire logic [31:0] thread_id_i,
  input  wire logic [31:0] main_device_i,
  input  wire logic [31:0] sub_device_i,
  input  wire logic [63:0] inode_i,
  input  wire logic [63:0] file_offset_i,
  input  wire logic [63:0] request_bytes_i,
  input  wire logic [63:0] enter_size_i,
  input  wire logic signed [63:0] actual_bytes_i,
  input  wire logic [63:0] file_id_i,
  output logic             done_o,
  output logic [2:0]       result_kind_o,
  output logic [63:0]      start_ts_o,
  output logic [63:0]      duration_o,
  output logic [63:0]      entry_offset_o,
  output logic [63:0]      entry_size_o,
  output logic [63:0]      entry_file_id_o
);
  import fpio_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_TAIL   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  logic [1:0]             state_q, state_d;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [31:0]            counter_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic                   cmp_en_q;
  logic                   cmp_valid_q;
  logic [IDX_W-1:0]       cmp_idx_q;
  exit_key_t              key_q;

  logic                   accept;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic                   store;
  logic                   scanning;
  slot_t                  wr_slot;
  slot_t                  rd_slot;
  cmp_ctrl_t              cmp_ctrl;
  best_t                  best;

  logic                   done_q;
  logic [2:0]             kind_q;
  logic [63:0]            start_ts_q;
  logic [63:0]            duration_q;
  logic [63:0]            offset_q;
  logic [63:0]            size_q;
  logic [63:0]            fid_q;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign scanning = (state_q == ST_SCAN);

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign store = accept && (mode_i == MODE_ENTER) && free_found;

  // Pack the enter item for the table
  always_comb begin
    wr_slot.order         = counter_q;
    wr_slot.ts            = timestamp_i;
    wr_slot.thread_id     = thread_id_i;
    wr_slot.is_write      = is_write_i;
    wr_slot.main_device   = main_device_i;
    wr_slot.sub_device    = sub_device_i;
    wr_slot.inode         = inode_i;
    wr_slot.file_offset   = file_offset_i;
    wr_slot.request_bytes = request_bytes_i;
    wr_slot.enter_size    = enter_size_i;
    wr_slot.file_id       = file_id_i;
  end

  fpio_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (free_idx),
    .wdata_i (wr_slot),
    .re_i    (scanning),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_slot)
  );

  assign cmp_ctrl.init       = accept && (mode_i == MODE_EXIT);
  assign cmp_ctrl.cmp_en     = cmp_en_q;
  assign cmp_ctrl.slot_valid = cmp_valid_q;
  assign cmp_ctrl.idx        = cmp_idx_q;

  fpio_match u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cmp_ctrl),
    .slot_i    (rd_slot),
    .key_i     (key_q),
    .counter_i (counter_q),
    .best_o    (best)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (mode_i == MODE_EXIT)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_q == LAST_IDX) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL:   state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control state: sequencer, valid bits, counter, read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      counter_q   <= '0;
      rd_idx_q    <= '0;
      cmp_en_q    <= 1'b0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      cmp_en_q    <= scanning;
      cmp_valid_q <= valid_q[rd_idx_q];
      cmp_idx_q   <= rd_idx_q;
      if (accept) begin
        rd_idx_q <= '0;
      end else if (scanning) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (store) begin
        valid_q[free_idx] <= 1'b1;
        counter_q         <= counter_q + 32'd1;
      end else if (accept && (mode_i == MODE_CLEAR)) begin
        valid_q <= '0;
      end else if ((state_q == ST_FINISH) && best.found) begin
        valid_q[best.idx] <= 1'b0;
      end
    end
  end

  // Latch the exit item's fields
  always_ff @(posedge clk_i) begin
    if (accept && (mode_i == MODE_EXIT)) begin
      key_q.ts            <= timestamp_i;
      key_q.thread_id     <= thread_id_i;
      key_q.is_write      <= is_write_i;
      key_q.main_device   <= main_device_i;
      key_q.sub_device    <= sub_device_i;
      key_q.inode         <= inode_i;
      key_q.file_offset   <= file_offset_i;
      key_q.request_bytes <= request_bytes_i;
      key_q.actual_bytes  <= actual_bytes_i;
    end
  end

  // Result strobe and kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      kind_q <= KIND_STORED;
    end else begin
      done_q <= 1'b0;
      if (accept && (mode_i == MODE_ENTER)) begin
        done_q <= 1'b1;
        kind_q <= free_found ? KIND_STORED : KIND_FULL;
      end else if (accept && (mode_i == MODE_CLEAR)) begin
        done_q <= 1'b1;
        kind_q <= KIND_CLEARED;
      end else if (state_q == ST_FINISH) begin
        done_q <= 1'b1;
        kind_q <= best.found ? KIND_MATCHED : KIND_UNMATCHED;
      end
    end
  end

  // Result payload: zero unless an exit matched
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && best.found) begin
      start_ts_q <= best.ts;
      duration_q <= ((key_q.ts != TS_INVALID) && (best.ts != TS_INVALID)) ?
                    (key_q.ts - best.ts) : TS_INVALID;
      offset_q   <= best.file_offset;
      size_q     <= best.enter_size;
      fid_q      <= best.file_id;
    end else begin
      start_ts_q <= '0;
      duration_q <= '0;
      offset_q   <= '0;
      size_q     <= '0;
      fid_q      <= '0;
    end
  end

  assign done_o          = done_q;
  assign result_kind_o   = kind_q;
  assign start_ts_o      = start_ts_q;
  assign duration_o      = duration_q;
  assign entry_offset_o  = offset_q;
  assign entry_size_o    = size_q;
  assign entry_file_id_o = fid_q;

endmodule

`default_nettype wire

// ----- rtl/fpio_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fpio_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/fpio_match.sv -----
// Shared compare unit: checks one table entry per cycle against an exit item
// and keeps the best candidate.
`default_nettype none

module fpio_match (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fpio_pkg::cmp_ctrl_t ctrl_i,
  input  wire fpio_pkg::slot_t     slot_i,
  input  wire fpio_pkg::exit_key_t key_i,
  input  wire logic [31:0]        counter_i,
  output fpio_pkg::best_t          best_o
);
  import fpio_pkg::*;

  logic        found_q;
  logic [IDX_W-1:0] idx_q;
  logic [63:0] ts_q;
  logic [63:0] offset_q;
  logic [63:0] size_q;
  logic [63:0] fid_q;
  logic [31:0] age_q;

  logic        keys_eq;
  logic        offset_ok;
  logic        is_match;
  logic        is_better;
  logic [31:0] age;
  logic [63:0] end_offset;

  // Match test for the entry now on the read port
  always_comb begin
    keys_eq = (slot_i.thread_id == key_i.thread_id) &&
              (slot_i.is_write == key_i.is_write) &&
              (slot_i.main_device == key_i.main_device) &&
              (slot_i.sub_device == key_i.sub_device) &&
              (slot_i.inode == key_i.inode) &&
              (slot_i.request_bytes == key_i.request_bytes);
    end_offset = slot_i.file_offset + key_i.actual_bytes;
    offset_ok  = (end_offset == key_i.file_offset);
    is_match   = ctrl_i.slot_valid && !key_i.actual_bytes[63] && keys_eq &&
                 (slot_i.ts < key_i.ts) && offset_ok;
    age        = counter_i - slot_i.order;
    is_better  = !found_q || (slot_i.ts > ts_q) || ((slot_i.ts == ts_q) && (age > age_q));
  end

  // Track found flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.init) begin
      found_q <= 1'b0;
    end else if (ctrl_i.cmp_en && is_match) begin
      found_q <= 1'b1;
    end
  end

  // Hold the best candidate's data
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en && is_match && is_better) begin
      idx_q    <= ctrl_i.idx;
      ts_q     <= slot_i.ts;
      offset_q <= slot_i.file_offset;
      size_q   <= slot_i.enter_size;
      fid_q    <= slot_i.file_id;
      age_q    <= age;
    end
  end

  assign best_o.found       = found_q;
  assign best_o.idx         = idx_q;
  assign best_o.ts          = ts_q;
  assign best_o.file_offset = offset_q;
  assign best_o.enter_size  = size_q;
  assign best_o.file_id     = fid_q;

endmodule

`default_nettype wire
